[rtl/afp_pkg.sv]
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the ASCII I/O frame parser: character codes,
// result kinds, parse phases, register indexes and the result record.
// ----------------------------------------------------------------------------
package afp_pkg;

   // character codes
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // result kinds
   localparam logic [2:0] KIND_DIGITAL = 3'd0;
   localparam logic [2:0] KIND_ANALOG  = 3'd1;
   localparam logic [2:0] KIND_HOUR    = 3'd2;
   localparam logic [2:0] KIND_MINUTE  = 3'd3;
   localparam logic [2:0] KIND_SECOND  = 3'd4;
   localparam logic [2:0] KIND_STATUS  = 3'd5;

   // parse phases
   localparam logic [2:0] PH_FIRST  = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_OPEN   = 3'd2;
   localparam logic [2:0] PH_FIELD  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // number conversion stages
   localparam logic [1:0] AT_SKIP = 2'd0;
   localparam logic [1:0] AT_NUM  = 2'd1;
   localparam logic [1:0] AT_END  = 2'd2;

   // remote header layout: 'A' plus three time pairs
   localparam int REMOTE_HDR_LEN = 7;
   localparam int POS_HOUR       = 2;
   localparam int POS_MINUTE     = 4;
   localparam int POS_SECOND     = 6;

   // register indexes
   localparam logic [2:0] REG_MAIN_DIG   = 3'd0;
   localparam logic [2:0] REG_MAIN_ANA   = 3'd1;
   localparam logic [2:0] REG_MAIN_MIN   = 3'd2;
   localparam logic [2:0] REG_MAIN_MAX   = 3'd3;
   localparam logic [2:0] REG_REMOTE_DIG = 3'd4;
   localparam logic [2:0] REG_REMOTE_ANA = 3'd5;
   localparam logic [2:0] REG_REMOTE_MIN = 3'd6;
   localparam logic [2:0] REG_REMOTE_MAX = 3'd7;

   // register reset values
   localparam logic [6:0]  RST_MAIN_DIG   = 7'd16;
   localparam logic [6:0]  RST_MAIN_ANA   = 7'd8;
   localparam logic [10:0] RST_MAIN_MIN   = 11'd2;
   localparam logic [10:0] RST_MAIN_MAX   = 11'd1024;
   localparam logic [6:0]  RST_REMOTE_DIG = 7'd7;
   localparam logic [6:0]  RST_REMOTE_ANA = 7'd3;
   localparam logic [10:0] RST_REMOTE_MIN = 11'd2;
   localparam logic [10:0] RST_REMOTE_MAX = 11'd1024;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // stream widths
   localparam int TDATA_W = 40;
   localparam int TUSER_W = 4;

   typedef struct packed {
      logic [6:0]  main_digital_count;
      logic [6:0]  main_analog_count;
      logic [10:0] main_min_length;
      logic [10:0] main_max_length;
      logic [6:0]  remote_digital_count;
      logic [6:0]  remote_analog_count;
      logic [10:0] remote_min_length;
      logic [10:0] remote_max_length;
   } afp_cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               station;
      logic [5:0]         channel;
      logic signed [31:0] value;
      logic               frame_ok;
      logic               last;
   } afp_rsp_type;

   // up to two results per byte; slot b is used only with slot a
   typedef struct packed {
      logic        valid_a;
      afp_rsp_type rsp_a;
      logic        valid_b;
      afp_rsp_type rsp_b;
   } afp_push_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       remote;
   } afp_core_stat_type;

   function automatic logic [6:0] clamp_count(input logic [6:0] c, input logic [6:0] lim);
      return (c > lim) ? lim : c;
   endfunction

endpackage

[rtl/afp_core.sv]
// ----------------------------------------------------------------------------
// afp_core
// Per-byte frame parse: header, digital digits, remote time pairs, analog
// field conversion and the end-of-frame status. One byte per fire.
// ----------------------------------------------------------------------------
module afp_core #(
   parameter int MAX_FRAME_LEN   = 1024,
   parameter int MAX_FIELD_CHARS = 15,
   parameter int MAX_CHANNELS    = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [7:0]                 byte_in,
   input  logic                       last_in,
   input  afp_pkg::afp_cfg_type       cfg,
   output afp_pkg::afp_push_type      push,
   output afp_pkg::afp_core_stat_type stat
);
   import afp_pkg::*;

   localparam int PW = $clog2(MAX_FRAME_LEN + 1);
   localparam int EW = (PW > 8) ? PW : 8;
   localparam int CW = (PW + 1 > 12) ? PW + 1 : 12;
   localparam logic [PW-1:0] POS_LIMIT   = PW'(MAX_FRAME_LEN);
   localparam logic [3:0]    FIELD_LIMIT = 4'(MAX_FIELD_CHARS);
   localparam logic [6:0]    CHAN_LIMIT  = 7'(MAX_CHANNELS);

   // frame state
   logic          remote_ff, remote_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [2:0]    phase_ff, phase_in;
   logic [31:0]   acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic [1:0]    atoi_ff, atoi_in;
   logic [3:0]    fcnt_ff, fcnt_in;
   logic [6:0]    aidx_ff, aidx_in;
   logic          fvalid_ff, fvalid_in;
   logic          term_ff, term_in;
   logic [7:0]    prev_ff, prev_in;

   // working values
   logic          parse_en;
   logic [6:0]    hs, dc, ac;
   logic [EW-1:0] pos_e, hs_e, dig_end;
   logic          is_digit, is_space, is_sign;
   logic [35:0]   mul;
   logic [31:0]   fval;
   logic [CW-1:0] len, lo, hi;
   logic          ok;
   logic          have_data;
   afp_rsp_type   data_rsp, stat_rsp;

   assign is_digit = byte_in inside {[CH_0:CH_9]};
   assign is_space = byte_in inside {CH_SP, [CH_TAB:CH_CR]};
   assign is_sign  = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);

   // acc * 10 + digit, saturated at 2^31
   assign mul  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 36'(byte_in - CH_0);
   assign fval = neg_ff ? (32'd0 - acc_ff) : (acc_ff[31] ? 32'h7FFF_FFFF : acc_ff);

   assign pos_e = EW'(pos_ff);

   // next state and results for one byte
   always_comb begin
      remote_in = remote_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      atoi_in   = atoi_ff;
      fcnt_in   = fcnt_ff;
      aidx_in   = aidx_ff;
      fvalid_in = fvalid_ff;
      parse_en  = 1'b1;
      have_data = 1'b0;
      data_rsp  = '0;
      stat_rsp  = '0;
      ok        = 1'b0;
      hs        = '0;
      dc        = '0;
      ac        = '0;
      hs_e      = '0;
      dig_end   = '0;

      if (pos_ff >= POS_LIMIT) begin
         fvalid_in = 1'b0;
      end else begin
         // first byte picks the format
         if (phase_ff == PH_FIRST) begin
            remote_in = (byte_in == CH_A);
            phase_in  = PH_HEADER;
            if (byte_in == CH_A) begin
               parse_en = 1'b0;
            end
         end
         hs = remote_in ? 7'(REMOTE_HDR_LEN) : 7'd0;
         dc = clamp_count(remote_in ? cfg.remote_digital_count : cfg.main_digital_count,
                          CHAN_LIMIT);
         ac = clamp_count(remote_in ? cfg.remote_analog_count : cfg.main_analog_count,
                          CHAN_LIMIT);
         hs_e    = EW'(hs);
         dig_end = EW'(hs) + EW'(dc);

         // header: time pairs and digital digits
         if (parse_en && phase_in == PH_HEADER) begin
            if (pos_e < hs_e) begin
               data_rsp.value = {16'b0, prev_ff, byte_in};
               if (pos_e == EW'(POS_HOUR)) begin
                  have_data     = 1'b1;
                  data_rsp.kind = KIND_HOUR;
               end else if (pos_e == EW'(POS_MINUTE)) begin
                  have_data     = 1'b1;
                  data_rsp.kind = KIND_MINUTE;
               end else if (pos_e == EW'(POS_SECOND)) begin
                  have_data     = 1'b1;
                  data_rsp.kind = KIND_SECOND;
               end
            end else if (pos_e < dig_end) begin
               if (is_digit) begin
                  have_data        = 1'b1;
                  data_rsp.kind    = KIND_DIGITAL;
                  data_rsp.channel = 6'(pos_e - hs_e);
                  data_rsp.value   = 32'(byte_in - CH_0);
               end else begin
                  fvalid_in = 1'b0;
               end
            end else begin
               phase_in = PH_OPEN;
            end
         end

         // analog part
         if (parse_en && phase_in == PH_OPEN) begin
            if (byte_in == CH_A) begin
               acc_in   = '0;
               neg_in   = 1'b0;
               atoi_in  = AT_SKIP;
               fcnt_in  = '0;
               phase_in = PH_FIELD;
            end else begin
               if (byte_in != CH_Z) begin
                  fvalid_in = 1'b0;
               end
               phase_in = PH_DONE;
            end
         end else if (parse_en && phase_in == PH_FIELD) begin
            if (byte_in == CH_A || byte_in == CH_Z) begin
               if (aidx_ff < ac) begin
                  have_data        = 1'b1;
                  data_rsp.kind    = KIND_ANALOG;
                  data_rsp.channel = 6'(aidx_ff);
                  data_rsp.value   = fval;
                  aidx_in          = aidx_ff + 7'd1;
                  if (byte_in == CH_Z) begin
                     phase_in = PH_DONE;
                  end else begin
                     acc_in  = '0;
                     neg_in  = 1'b0;
                     atoi_in = AT_SKIP;
                     fcnt_in = '0;
                  end
               end else begin
                  phase_in = PH_DONE;
               end
            end else if (fcnt_ff < FIELD_LIMIT) begin
               // atoi on one character
               fcnt_in = fcnt_ff + 4'd1;
               if (atoi_ff == AT_SKIP && is_space) begin
                  atoi_in = AT_SKIP;
               end else if (atoi_ff == AT_SKIP && is_sign) begin
                  neg_in  = (byte_in == CH_MINUS);
                  atoi_in = AT_NUM;
               end else if (atoi_ff != AT_END && is_digit) begin
                  acc_in  = (mul > 36'h8000_0000) ? 32'h8000_0000 : mul[31:0];
                  atoi_in = AT_NUM;
               end else begin
                  atoi_in = AT_END;
               end
            end
         end
         pos_in = pos_ff + PW'(1);
      end

      data_rsp.station = remote_in;
      term_in = (byte_in == CH_Z);
      prev_in = byte_in;

      // end of frame: status and clear
      len = CW'(pos_ff) + CW'(1);
      lo  = CW'(remote_in ? cfg.remote_min_length : cfg.main_min_length);
      hi  = CW'(remote_in ? cfg.remote_max_length : cfg.main_max_length);
      if (last_in) begin
         ok = fvalid_in && (phase_in == PH_DONE) && (len >= lo) && (len <= hi) &&
              (len <= CW'(MAX_FRAME_LEN));
         if (remote_in) begin
            ok = ok && (len >= CW'(2)) && term_ff;
         end else begin
            ok = ok && (byte_in == CH_Z);
         end
         stat_rsp.kind     = KIND_STATUS;
         stat_rsp.station  = remote_in;
         stat_rsp.frame_ok = ok;
         stat_rsp.last     = 1'b1;
         remote_in = 1'b0;
         pos_in    = '0;
         phase_in  = PH_FIRST;
         acc_in    = '0;
         neg_in    = 1'b0;
         atoi_in   = AT_SKIP;
         fcnt_in   = '0;
         aidx_in   = '0;
         fvalid_in = 1'b1;
         term_in   = 1'b0;
         prev_in   = '0;
      end
   end

   // compact results: status fills slot a when there is no data result
   always_comb begin
      push = '0;
      if (have_data) begin
         push.valid_a = fire;
         push.rsp_a   = data_rsp;
         push.valid_b = fire && last_in;
         push.rsp_b   = stat_rsp;
      end else begin
         push.valid_a = fire && last_in;
         push.rsp_a   = stat_rsp;
      end
   end

   assign stat.phase  = phase_ff;
   assign stat.remote = remote_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         remote_ff <= 1'b0;
         pos_ff    <= '0;
         phase_ff  <= PH_FIRST;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         atoi_ff   <= AT_SKIP;
         fcnt_ff   <= '0;
         aidx_ff   <= '0;
         fvalid_ff <= 1'b1;
         term_ff   <= 1'b0;
         prev_ff   <= '0;
      end else if (fire) begin
         remote_ff <= remote_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         atoi_ff   <= atoi_in;
         fcnt_ff   <= fcnt_in;
         aidx_ff   <= aidx_in;
         fvalid_ff <= fvalid_in;
         term_ff   <= term_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

[rtl/afp_out_q.sv]
// ----------------------------------------------------------------------------
// afp_out_q
// Small result queue: takes up to two results per cycle, hands out one per
// beat. Lets the parser run on while the receiver stalls, as far as its room allows.
// ----------------------------------------------------------------------------
module afp_out_q (
   input  logic                      clock,
   input  logic                      reset,
   input  afp_pkg::afp_push_type     push,
   input  logic                      pop_ready,
   output logic                      out_valid,
   output afp_pkg::afp_rsp_type      out_rsp,
   output logic [afp_pkg::QCNT_W-1:0] count
);
   import afp_pkg::*;

   afp_rsp_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [QCNT_W-1:0]  n_push;
   logic               pop;

   assign out_valid = (cnt_ff != '0);
   assign out_rsp   = mem_ff[rd_ff];
   assign count     = cnt_ff;
   assign pop       = out_valid && pop_ready;
   assign n_push    = QCNT_W'(push.valid_a) + QCNT_W'(push.valid_b);

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff + QPTR_W'(n_push);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + n_push - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         mem_ff[wr_ff] <= push.rsp_a;
      end
      if (push.valid_b) begin
         mem_ff[wr_ff + QPTR_W'(1)] <= push.rsp_b;
      end
   end

endmodule

[rtl/ascii_io_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// ascii_io_frame_parser_unit
// ASCII I/O frame parser, one received byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : one frame byte per beat in req_tdata, req_tlast on the final byte.
//  rsp_*  : digital, time and analog results, then one status result with
//           rsp_tlast high that closes the frame; commit only if frame_ok.
//  csr_*  : register writes, index 0..7, taken at once (csr_ready is high).
//           Write only while no frame results are pending.
// Timing: a byte lands in the input register on acceptance and is parsed in
//  the next cycle if the queue has room for two results; its results are
//  registered into a four-entry result queue and shown on rsp_* from there.
//  One byte per cycle is sustained while rsp_tready is high and each byte
//  gives at most one result; a frame's final byte can give two (data plus
//  status), and the queue's free room (two entries needed) gates parsing.
// Reset: registers return to their reset values, parse state to the start
//  of a frame, queue empties.
// Stall: when rsp_tready is low the queue fills and then req_tready drops;
//  nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ascii_io_frame_parser_unit #(
   parameter int MAX_FRAME_LEN   = 1024,
   parameter int MAX_FIELD_CHARS = 15,
   parameter int MAX_CHANNELS    = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte_req[7:0]
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tlast,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // channel[5:0], value[37:6], frame_ok[38], zero[39]
   output logic [afp_pkg::TDATA_W-1:0]   rsp_tdata,
   // kind[2:0], station[3]
   output logic [afp_pkg::TUSER_W-1:0]   rsp_tuser,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [10:0]                   csr_data
);
   import afp_pkg::*;

   afp_cfg_type        cfg_ff;
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_last_ff;
   logic               proc;
   afp_push_type       push;
   afp_core_stat_type  core_stat;
   afp_rsp_type        out_rsp;
   logic [QCNT_W-1:0]  q_cnt;

   // parse the held byte when the queue has room for two results
   assign proc       = s1_valid_ff && (q_cnt <= QCNT_W'(QDEPTH - 2));
   assign req_tready = !s1_valid_ff || proc;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_digital_count   <= RST_MAIN_DIG;
         cfg_ff.main_analog_count    <= RST_MAIN_ANA;
         cfg_ff.main_min_length      <= RST_MAIN_MIN;
         cfg_ff.main_max_length      <= RST_MAIN_MAX;
         cfg_ff.remote_digital_count <= RST_REMOTE_DIG;
         cfg_ff.remote_analog_count  <= RST_REMOTE_ANA;
         cfg_ff.remote_min_length    <= RST_REMOTE_MIN;
         cfg_ff.remote_max_length    <= RST_REMOTE_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAIN_DIG:   cfg_ff.main_digital_count   <= csr_data[6:0];
            REG_MAIN_ANA:   cfg_ff.main_analog_count    <= csr_data[6:0];
            REG_MAIN_MIN:   cfg_ff.main_min_length      <= csr_data;
            REG_MAIN_MAX:   cfg_ff.main_max_length      <= csr_data;
            REG_REMOTE_DIG: cfg_ff.remote_digital_count <= csr_data[6:0];
            REG_REMOTE_ANA: cfg_ff.remote_analog_count  <= csr_data[6:0];
            REG_REMOTE_MIN: cfg_ff.remote_min_length    <= csr_data;
            REG_REMOTE_MAX: cfg_ff.remote_max_length    <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (proc) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   afp_core #(
      .MAX_FRAME_LEN   (MAX_FRAME_LEN),
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
      .MAX_CHANNELS    (MAX_CHANNELS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (proc),
      .byte_in (s1_byte_ff),
      .last_in (s1_last_ff),
      .cfg     (cfg_ff),
      .push    (push),
      .stat    (core_stat)
   );

   afp_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_rsp   (out_rsp),
      .count     (q_cnt)
   );

   assign rsp_tdata = {1'b0, out_rsp.frame_ok, out_rsp.value, out_rsp.channel};
   assign rsp_tuser = {out_rsp.station, out_rsp.kind};
   assign rsp_tlast = out_rsp.last;

   // checks
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2:0] == KIND_STATUS)
      else $error("frame close beat without status kind");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      proc && s1_last_ff |=> core_stat.phase == PH_FIRST)
      else $error("parser not back at frame start after final byte");

   a_idle_main: assert property (@(posedge clock) disable iff (reset)
      core_stat.phase == PH_FIRST |-> !core_stat.remote)
      else $error("remote mode set before first byte");

endmodule
